>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled during
// reset by i_rst_n of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define SSD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// Types and codes shared by the segment stream deframer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // ids at or above this are rejected
    localparam int MAX_STREAMS = 32;

    // result kinds
    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_EMPTY   = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MAGIC    = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;
    localparam logic [1:0] ERR_PROPERTY = 2'd3;

    // register index of source_limit
    localparam logic REG_SOURCE_LIMIT = 1'b0;
    localparam logic [3:0] SOURCE_LIMIT_RST = 4'd8;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload;
        logic [4:0] stream_id;
        logic [2:0] stream_source;
        logic       first_in_segment;
        logic       last_of_stream;
        logic       last_of_segment;
        logic [1:0] error_code;
    } t_result;

endpackage

`default_nettype wire

>>> design/ssd_cfg.sv
// ---------------------------------------------------------------------------
// ssd_cfg
// APB register file holding source_limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic      [3:0]  o_source_limit
);
    import ssd_pkg::*;

    logic [3:0] r_source_limit;
    logic       sel_limit;
    logic       wr_en;

    assign sel_limit = (i_paddr[2] == REG_SOURCE_LIMIT);
    assign wr_en     = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_limit <= SOURCE_LIMIT_RST;
        end else if (wr_en && sel_limit) begin
            r_source_limit <= i_pwdata[3:0];
        end
    end

    always_comb begin
        o_prdata = 32'd0;
        if (sel_limit) begin
            o_prdata = {28'd0, r_source_limit};
        end
    end

    assign o_source_limit = r_source_limit;

endmodule

`default_nettype wire

>>> design/ssd_in_stage.sv
// ---------------------------------------------------------------------------
// ssd_in_stage
// Input register for the raw byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data,
    input  wire logic       i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output logic      [7:0] o_data
);
    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> design/ssd_parse.sv
// ---------------------------------------------------------------------------
// ssd_parse
// Segment parser: magic, mask, stream headers and payload counting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_parse (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [3:0] i_source_limit,
    output logic            o_emit,
    output ssd_pkg::t_result o_res
);
    import ssd_pkg::*;

    localparam logic [1:0] PH_MAGIC  = 2'd0;
    localparam logic [1:0] PH_MASK   = 2'd1;
    localparam logic [1:0] PH_HEADER = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    localparam logic [7:0] MAGIC_0 = 8'h53; // S
    localparam logic [7:0] MAGIC_1 = 8'h47; // G
    localparam logic [7:0] MAGIC_2 = 8'h49; // I
    localparam logic [7:0] MAGIC_3 = 8'h00;

    localparam logic [5:0] ID_LIMIT = 6'(MAX_STREAMS);

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'd0, v[k]};
        end
        return c;
    endfunction

    logic [1:0]  r_phase,        n_phase;
    logic [2:0]  r_hdr_idx,      n_hdr_idx;
    logic        r_magic_ok,     n_magic_ok;
    logic [5:0]  r_ones,         n_ones;
    logic [23:0] r_len,          n_len;
    logic [5:0]  r_streams_left, n_streams_left;
    logic [5:0]  r_streams_tot,  n_streams_tot;
    logic [31:0] r_bytes_left,   n_bytes_left;
    logic [4:0]  r_cur_id,       n_cur_id;
    logic [2:0]  r_cur_src,      n_cur_src;

    logic [7:0]  magic_byte;
    logic        magic_ok;
    logic [5:0]  ones_sum;
    logic [31:0] len_full;
    logic [5:0]  left_dec;
    logic        data_last;
    logic        emit;
    t_result     res;

    always_comb begin
        case (r_hdr_idx[1:0])
            2'd0:    magic_byte = MAGIC_0;
            2'd1:    magic_byte = MAGIC_1;
            2'd2:    magic_byte = MAGIC_2;
            default: magic_byte = MAGIC_3;
        endcase
    end

    assign magic_ok  = ((r_hdr_idx[1:0] == 2'd0) || r_magic_ok) && (i_data_byte == magic_byte);
    assign ones_sum  = ((r_hdr_idx[1:0] == 2'd0) ? 6'd0 : r_ones) + {2'd0, ones8(i_data_byte)};
    assign len_full  = {i_data_byte, r_len};
    assign left_dec  = r_streams_left - 6'd1;
    assign data_last = (r_bytes_left[31:1] == 31'd0);

    always_comb begin
        n_phase        = r_phase;
        n_hdr_idx      = r_hdr_idx;
        n_magic_ok     = r_magic_ok;
        n_ones         = r_ones;
        n_len          = r_len;
        n_streams_left = r_streams_left;
        n_streams_tot  = r_streams_tot;
        n_bytes_left   = r_bytes_left;
        n_cur_id       = r_cur_id;
        n_cur_src      = r_cur_src;
        emit           = 1'b0;

        res                  = '0;
        res.stream_id        = r_cur_id;
        res.stream_source    = r_cur_src;
        res.first_in_segment = (r_streams_left == r_streams_tot);
        res.error_code       = ERR_NONE;

        unique case (r_phase)
            PH_MAGIC: begin
                n_magic_ok = magic_ok;
                n_hdr_idx  = r_hdr_idx + 3'd1;
                if (r_hdr_idx[1:0] == 2'd3) begin
                    n_hdr_idx = 3'd0;
                    if (magic_ok) begin
                        n_phase = PH_MASK;
                    end else begin
                        emit = 1'b1;
                        res  = '0;
                        res.event_res  = EV_ERROR;
                        res.error_code = ERR_MAGIC;
                    end
                end
            end
            PH_MASK: begin
                n_ones    = ones_sum;
                n_hdr_idx = r_hdr_idx + 3'd1;
                if (r_hdr_idx[1:0] == 2'd3) begin
                    n_hdr_idx      = 3'd0;
                    n_streams_tot  = ones_sum;
                    n_streams_left = ones_sum;
                    // empty mask: back to hunting for the magic
                    n_phase        = (ones_sum != 6'd0) ? PH_HEADER : PH_MAGIC;
                end
            end
            PH_HEADER: begin
                if (r_hdr_idx == 3'd0) begin
                    n_cur_id  = i_data_byte[7:3];
                    n_cur_src = i_data_byte[2:0];
                    n_hdr_idx = 3'd1;
                    if (({1'b0, i_data_byte[7:3]} >= ID_LIMIT) ||
                        ({1'b0, i_data_byte[2:0]} >= i_source_limit)) begin
                        n_phase   = PH_MAGIC;
                        n_hdr_idx = 3'd0;
                        emit      = 1'b1;
                        res       = '0;
                        res.event_res  = EV_ERROR;
                        res.error_code = ERR_RANGE;
                    end
                end else if (r_hdr_idx == 3'd1) begin
                    n_hdr_idx = 3'd2;
                    if (i_data_byte != 8'd0) begin
                        n_phase   = PH_MAGIC;
                        n_hdr_idx = 3'd0;
                        emit      = 1'b1;
                        res       = '0;
                        res.event_res  = EV_ERROR;
                        res.error_code = ERR_PROPERTY;
                    end
                end else if (r_hdr_idx == 3'd5) begin
                    n_hdr_idx = 3'd0;
                    if (len_full == 32'd0) begin
                        // empty stream: one marker, then the next stream header or the magic hunt
                        emit                = 1'b1;
                        res.event_res       = EV_EMPTY;
                        res.last_of_stream  = 1'b1;
                        res.last_of_segment = (r_streams_left == 6'd1);
                        n_streams_left      = left_dec;
                        n_phase             = (left_dec != 6'd0) ? PH_HEADER : PH_MAGIC;
                    end else begin
                        n_bytes_left = len_full;
                        n_phase      = PH_DATA;
                    end
                end else begin
                    // length bytes 0..2, little endian
                    case (r_hdr_idx)
                        3'd2:    n_len[7:0]   = i_data_byte;
                        3'd3:    n_len[15:8]  = i_data_byte;
                        default: n_len[23:16] = i_data_byte;
                    endcase
                    n_hdr_idx = r_hdr_idx + 3'd1;
                end
            end
            default: begin
                emit                = 1'b1;
                res.event_res       = EV_PAYLOAD;
                res.payload         = i_data_byte;
                res.last_of_stream  = data_last;
                res.last_of_segment = data_last && (r_streams_left == 6'd1);
                n_bytes_left        = r_bytes_left - 32'd1;
                if (data_last) begin
                    n_bytes_left   = 32'd0;
                    n_streams_left = left_dec;
                    n_hdr_idx      = 3'd0;
                    n_phase        = (left_dec != 6'd0) ? PH_HEADER : PH_MAGIC;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MAGIC;
            r_hdr_idx      <= 3'd0;
            r_magic_ok     <= 1'b0;
            r_ones         <= 6'd0;
            r_streams_left <= 6'd0;
            r_streams_tot  <= 6'd0;
            r_bytes_left   <= 32'd0;
            r_cur_id       <= 5'd0;
            r_cur_src      <= 3'd0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_hdr_idx      <= n_hdr_idx;
            r_magic_ok     <= n_magic_ok;
            r_ones         <= n_ones;
            r_streams_left <= n_streams_left;
            r_streams_tot  <= n_streams_tot;
            r_bytes_left   <= n_bytes_left;
            r_cur_id       <= n_cur_id;
            r_cur_src      <= n_cur_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_len <= n_len;
        end
    end

    assign o_emit = i_step && emit;
    assign o_res  = res;

endmodule

`default_nettype wire

>>> design/ssd_out_stage.sv
// ---------------------------------------------------------------------------
// ssd_out_stage
// Result register in front of the output stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_emit,
    input  wire ssd_pkg::t_result i_res,
    input  wire logic            i_ready,
    output logic                 o_advance,
    output logic                 o_valid,
    output ssd_pkg::t_result     o_res
);
    import ssd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free slot, or the held beat leaves this cycle
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_emit) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> design/segment_stream_deframer_unit.sv
// ---------------------------------------------------------------------------
// segment_stream_deframer_unit
// Splits a segmented byte stream into payload beats tagged by stream.
// ---------------------------------------------------------------------------
// Channel   Dir  Signals                              Content
// s_axis    in   tvalid/tready/tdata[7:0]             raw segment bytes
// m_axis    out  tvalid/tready/tdata[23:0]/tuser/tlast tagged payload, markers, errors
// apb       in   psel/penable/pwrite/paddr/pwdata     source_limit at 0x0
//
// One byte per cycle sustained while m_axis takes beats: input register, one
// pass of parser logic, result register. Reset (synchronous, active low) puts
// the parser in magic hunt, source_limit 8. A stalled m_axis holds one result
// and one more byte in the input register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_stream_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] payload, [12:8] stream_id, [15:13] stream_source,
    // [16] first_in_segment, [17] last_of_segment, [19:18] error_code, [23:20] zero
    output logic      [23:0] m_axis_tdata,
    output logic      [1:0]  m_axis_tuser,   // [1:0] event_res
    output logic             m_axis_tlast,   // last_of_stream
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ssd_pkg::*;

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic [3:0] source_limit;
    logic       emit;
    t_result    res;
    logic       out_valid;
    t_result    out_res;
    logic       err_beat;
    logic       tag_beat;
    logic       mark_beat;
    logic       seg_end_beat;

    assign pready = 1'b1;

    ssd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_source_limit (source_limit)
    );

    ssd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_advance (advance),
        .o_ready   (s_axis_tready),
        .o_valid   (in_valid),
        .o_data    (in_byte)
    );

    ssd_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_valid && advance),
        .i_data_byte    (in_byte),
        .i_source_limit (source_limit),
        .o_emit         (emit),
        .o_res          (res)
    );

    ssd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (emit),
        .i_res     (res),
        .i_ready   (m_axis_tready),
        .o_advance (advance),
        .o_valid   (out_valid),
        .o_res     (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_res.event_res;
    assign m_axis_tlast  = out_res.last_of_stream;
    assign m_axis_tdata  = {4'd0, out_res.error_code, out_res.last_of_segment,
                            out_res.first_in_segment, out_res.stream_source,
                            out_res.stream_id, out_res.payload};

    assign err_beat     = m_axis_tvalid && (m_axis_tuser == EV_ERROR);
    assign tag_beat     = m_axis_tvalid && (m_axis_tuser != EV_ERROR);
    assign mark_beat    = m_axis_tvalid && (m_axis_tuser == EV_EMPTY);
    assign seg_end_beat = m_axis_tvalid && m_axis_tdata[17];

`include "assert_macros.svh"

    `SSD_ASSERT_IMPL(a_err_clean, err_beat, !m_axis_tlast && ~|m_axis_tdata[17:0], "stray tags")
    `SSD_ASSERT_IMPL(a_code_err, tag_beat, m_axis_tdata[19:18] == ERR_NONE, "stray error code")
    `SSD_ASSERT_IMPL(a_seg_end_stream, seg_end_beat, m_axis_tlast, "segment end mid stream")
    `SSD_ASSERT_IMPL(a_marker_form, mark_beat, m_axis_tlast && ~|m_axis_tdata[7:0], "bad marker")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_stream_deframer_unit. Segments go in on
// s_axis with random sender gaps. A scoreboard tracks the segment parser and
// checks each m_axis beat against the oldest expected result. source_limit is
// changed over APB between phases, only while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ssd_pkg::*;

    typedef enum logic [1:0] {HUNT_MAGIC, READ_MASK, READ_HDR, READ_DATA} t_parse_phase;

    // 'S','G','I',0 taken little-endian
    localparam logic [31:0] MAGIC_WORD     = 32'h0049_4753;
    localparam logic [2:0]  SRC_LIMIT_ADDR = {REG_SOURCE_LIMIT, 2'b00};
    localparam int          DRAIN_CYCLES   = 6;

    class deframer_scoreboard;
        t_result      expected_q[$];
        int           mismatches;
        int           bytes_noted;
        int           payload_beats;
        int           empty_markers;
        int           format_errors[4];
        logic [3:0]   source_limit;
        t_parse_phase phase;
        logic [2:0]   hdr_idx;
        logic [31:0]  shift;
        logic [5:0]   streams_left;
        logic [5:0]   streams_total;
        logic [31:0]  bytes_left;
        logic [4:0]   cur_id;
        logic [2:0]   cur_src;

        function new();
            source_limit  = SOURCE_LIMIT_RST;
            phase         = HUNT_MAGIC;
            hdr_idx       = '0;
            shift         = '0;
            streams_left  = '0;
            streams_total = '0;
            bytes_left    = '0;
            cur_id        = '0;
            cur_src       = '0;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function bit at_segment_start();
            return phase == HUNT_MAGIC && hdr_idx == 3'd0;
        endfunction

        function void push_error(logic [1:0] code);
            t_result r;
            r = '0;
            r.event_res  = EV_ERROR;
            r.error_code = code;
            expected_q.push_back(r);
            phase   = HUNT_MAGIC;
            hdr_idx = '0;
            shift   = '0;
        endfunction

        function void push_item(logic [1:0] ev, logic [7:0] pay, bit last);
            t_result r;
            r = '0;
            r.event_res        = ev;
            r.payload          = pay;
            r.stream_id        = cur_id;
            r.stream_source    = cur_src;
            r.first_in_segment = (streams_left == streams_total);
            r.last_of_stream   = last;
            r.last_of_segment  = last && streams_left == 6'd1;
            r.error_code       = ERR_NONE;
            expected_q.push_back(r);
        endfunction

        function void end_stream();
            streams_left = streams_left - 6'd1;
            phase        = (streams_left != 0) ? READ_HDR : HUNT_MAGIC;
            hdr_idx      = '0;
            shift        = '0;
        endfunction

        // Advance the parser by one accepted byte and queue what it should emit.
        function void note_byte(logic [7:0] b);
            int   ones;
            int   pos;
            bit   last;
            bytes_noted++;
            case (phase)
                HUNT_MAGIC, READ_MASK: begin
                    shift   = shift | ({24'd0, b} << (8 * hdr_idx[1:0]));
                    hdr_idx = hdr_idx + 3'd1;
                    if (hdr_idx >= 3'd4) begin
                        if (phase == HUNT_MAGIC) begin
                            if (shift != MAGIC_WORD) begin
                                push_error(ERR_MAGIC);
                            end else begin
                                phase   = READ_MASK;
                                hdr_idx = '0;
                                shift   = '0;
                            end
                        end else begin
                            ones          = $countones(shift);
                            streams_total = ones[5:0];
                            streams_left  = ones[5:0];
                            hdr_idx       = '0;
                            shift         = '0;
                            phase         = (ones != 0) ? READ_HDR : HUNT_MAGIC;
                        end
                    end
                end
                READ_HDR: begin
                    if (hdr_idx == 3'd0) begin
                        cur_id  = b[7:3];
                        cur_src = b[2:0];
                        if (int'(cur_id) >= MAX_STREAMS || {1'b0, cur_src} >= source_limit)
                            push_error(ERR_RANGE);
                        else
                            hdr_idx = 3'd1;
                    end else if (hdr_idx == 3'd1) begin
                        if (b != 8'd0) begin
                            push_error(ERR_PROPERTY);
                        end else begin
                            hdr_idx = 3'd2;
                            shift   = '0;
                        end
                    end else begin
                        pos     = int'(hdr_idx) - 2;
                        shift   = shift | ({24'd0, b} << (8 * pos));
                        hdr_idx = hdr_idx + 3'd1;
                        if (hdr_idx >= 3'd6) begin
                            bytes_left = shift;
                            hdr_idx    = '0;
                            shift      = '0;
                            if (bytes_left == 0) begin
                                push_item(EV_EMPTY, 8'd0, 1'b1);
                                end_stream();
                            end else begin
                                phase = READ_DATA;
                            end
                        end
                    end
                end
                default: begin
                    last = (bytes_left <= 32'd1);
                    push_item(EV_PAYLOAD, b, last);
                    bytes_left = last ? 32'd0 : bytes_left - 32'd1;
                    if (last) end_stream();
                end
            endcase
        endfunction

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat event %0d", got.event_res));
                return;
            end
            want = expected_q.pop_front();
            case (want.event_res)
                EV_PAYLOAD: payload_beats++;
                EV_EMPTY:   empty_markers++;
                default:    format_errors[want.error_code]++;
            endcase
            compare_field("event_res", int'(got.event_res), int'(want.event_res));
            compare_field("payload", int'(got.payload), int'(want.payload));
            compare_field("stream_id", int'(got.stream_id), int'(want.stream_id));
            compare_field("stream_source", int'(got.stream_source),
                          int'(want.stream_source));
            compare_field("first_in_segment", int'(got.first_in_segment),
                          int'(want.first_in_segment));
            compare_field("last_of_stream", int'(got.last_of_stream),
                          int'(want.last_of_stream));
            compare_field("last_of_segment", int'(got.last_of_segment),
                          int'(want.last_of_segment));
            compare_field("error_code", int'(got.error_code), int'(want.error_code));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'd0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic        rx_ready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    deframer_scoreboard sb;
    int                 tx_gap_pct = 0;
    int                 rx_stall_pct = 0;
    int                 phases_run = 0;

    segment_stream_deframer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (rx_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Check each result beat, then pick the next cycle's tready.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && rx_ready) begin
            got.event_res        = m_axis_tuser;
            got.payload          = m_axis_tdata[7:0];
            got.stream_id        = m_axis_tdata[12:8];
            got.stream_source    = m_axis_tdata[15:13];
            got.first_in_segment = m_axis_tdata[16];
            got.last_of_stream   = m_axis_tlast;
            got.last_of_segment  = m_axis_tdata[17];
            got.error_code       = m_axis_tdata[19:18];
            if (m_axis_tdata[23:20] != 4'd0) sb.flag_mismatch("nonzero tdata pad bits");
            sb.check_result(got);
        end
        if (!i_rst_n)
            rx_ready <= 1'b0;
        else
            rx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
    endtask

    task automatic send_word_le(logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8 * i +: 8]);
    endtask

    // Hold the input idle until every expected beat is out and the pipe is empty.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_source_limit(logic [3:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= SRC_LIMIT_ADDR;
        pwdata  <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.source_limit = value;
    endtask

    // One segment, mostly well formed; some noise, bad magic, zero mask,
    // out-of-range sources and nonzero property bytes.
    task automatic send_segment();
        int          pick;
        int          n_streams;
        int          len;
        int          src_cap;
        int          bad_pos;
        int          r;
        logic [31:0] mask;
        logic [31:0] magic;
        logic [4:0]  id;
        logic [2:0]  src;
        logic [7:0]  prop;
        bit          broken;
        // realign to a fresh group of four
        while (!sb.at_segment_start()) send_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        magic = MAGIC_WORD;
        if (pick < 13) begin
            bad_pos = $urandom_range(0, 3);
            magic[8 * bad_pos +: 8] = magic[8 * bad_pos +: 8] ^ 8'($urandom_range(1, 255));
        end
        send_word_le(magic);
        if (pick < 13) return;
        if (pick < 18) begin
            send_word_le(32'd0);
            return;
        end
        n_streams = ($urandom_range(0, 39) == 0) ? 32 : $urandom_range(1, 4);
        mask = '0;
        while ($countones(mask) < n_streams) mask[5'($urandom_range(0, 31))] = 1'b1;
        send_word_le(mask);
        src_cap = (sb.source_limit > 4'd8) ? 8 : int'(sb.source_limit);
        for (int s = 0; s < n_streams; s++) begin
            id = 5'($urandom_range(0, 31));
            if (src_cap == 0 || $urandom_range(0, 9) == 0)
                src = 3'($urandom_range(0, 7));
            else
                src = 3'($urandom_range(0, src_cap - 1));
            prop   = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            broken = ({1'b0, src} >= sb.source_limit) || prop != 8'd0;
            r = $urandom_range(0, 9);
            if (n_streams == 32)
                len = $urandom_range(0, 2);
            else if (r == 0)
                len = 0;
            else if (r == 1)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            // after a bad header the rest of it is hunted as magic
            send_byte({id, src});
            send_byte(prop);
            send_word_le(len);
            if (broken) return;
            repeat (len) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(logic [3:0] limit, int tx_pct, int rx_pct, int items);
        int target;
        drain();
        write_source_limit(limit);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        target = sb.bytes_noted + items;
        while (sb.bytes_noted < target) send_segment();
        phases_run++;
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gap_pct   = 28;
        rx_stall_pct = 49;
        // bad magic, then a two-stream segment: extreme id/source with a
        // single 0xff payload byte, and an empty stream ending the segment
        send_word_le({8'hff, MAGIC_WORD[23:0]});
        send_word_le(MAGIC_WORD);
        send_word_le(32'h8000_0001);
        send_byte(8'hff);
        send_byte(8'h00);
        send_word_le(32'd1);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h00);
        send_word_le(32'd0);

        // each phase runs past its target by the tail of its last segment
        run_phase(4'd1,  28, 49, 110);
        run_phase(4'd8,  28, 49, 110);
        run_phase(4'd15, 28, 49, 110);
        run_phase(4'd0,  49, 28, 110);
        run_phase(4'd5,  49, 28, 110);
        run_phase(4'd3,  49, 28, 110);
        run_phase(4'd8,   0,  0, 110);
        run_phase(4'd7,   0,  0, 110);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) sb.flag_mismatch("expected beats never arrived");
        $display("Sent %0d bytes over %0d random phases, source_limit 0..15 incl. extremes",
                 sb.bytes_noted, phases_run);
        $display("Checked %0d payload beats, %0d empty markers, errors magic/range/prop %0d/%0d/%0d",
                 sb.payload_beats, sb.empty_markers, sb.format_errors[ERR_MAGIC],
                 sb.format_errors[ERR_RANGE], sb.format_errors[ERR_PROPERTY]);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d beats still expected", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
